[rtl/core/kmst_pkg.sv]
// Shared types and constants for the Kruskal spanning tree block.
package kmst_pkg;

  localparam int unsigned VTX_W = 4;  // width of a vertex field
  localparam int unsigned VC_W  = 5;  // width of the vertex_count register
  localparam logic [VC_W-1:0] VC_RESET = 5'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the accepted edge
    logic init;        // start of a graph: clear parent store and pick state
    logic scan_begin;  // rewind the edge scan
    logic scan_read;   // issue one edge read
    logic pick;        // take the best edge of the finished scan
    logic walk_s;      // one root walk step from the source side
    logic walk_d;      // one root walk step from the destination side
    logic union_go;    // link roots, move pending edge out
    logic fin;         // emit final result, clear the load state
  } kmst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;        // enough tree edges or no edges stored
    logic scan_last;   // read of the last stored edge is issued now
    logic best_vld;    // the scan found a next edge
    logic walk_hit;    // current walk vertex is a root
    logic roots_eq;    // destination root equals source root
    logic pend_vld;    // a chosen edge waits to go out
    logic out_free;    // output register can take a result
  } kmst_stat_t;

endpackage

[rtl/core/kmst_ctrl.sv]
// Controller state machine for the Kruskal spanning tree block.
module kmst_ctrl
  import kmst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_last_i,
  output logic       in_ready_o,
  input  kmst_stat_t stat_i,
  output kmst_cmd_t  cmd_o
);

  typedef enum logic [9:0] {
    ST_LOAD     = 10'b0000000001,
    ST_INIT     = 10'b0000000010,
    ST_CHECK    = 10'b0000000100,
    ST_SCAN     = 10'b0000001000,
    ST_SCAN_END = 10'b0000010000,
    ST_PICK     = 10'b0000100000,
    ST_WALK_S   = 10'b0001000000,
    ST_WALK_D   = 10'b0010000000,
    ST_UNION    = 10'b0100000000,
    ST_FIN      = 10'b1000000000
  } kmst_state_e;

  kmst_state_e state_q, state_d;
  logic        accept;

  assign in_ready_o = (state_q == ST_LOAD);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.load = accept;
        if (accept && in_last_i) state_d = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.scan_begin = 1'b1;
        state_d          = stat_i.stop ? ST_FIN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_read = 1'b1;
        if (stat_i.scan_last) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: state_d = ST_PICK;
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = stat_i.best_vld ? ST_WALK_S : ST_FIN;
      end
      ST_WALK_S: begin
        cmd_o.walk_s = 1'b1;
        if (stat_i.walk_hit) state_d = ST_WALK_D;
      end
      ST_WALK_D: begin
        cmd_o.walk_d = 1'b1;
        if (stat_i.walk_hit) state_d = stat_i.roots_eq ? ST_CHECK : ST_UNION;
      end
      ST_UNION: begin
        if (!stat_i.pend_vld || stat_i.out_free) begin
          cmd_o.union_go = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else         state_q <= state_d;
  end

  // a result may only leave the union step when the output register can take it
  a_union_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.union_go |-> (!stat_i.pend_vld || stat_i.out_free))
    else $error("union with blocked output");
  a_one_cmd_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.walk_s && cmd_o.walk_d) && !(cmd_o.load && cmd_o.scan_read))
    else $error("conflicting commands");
  a_fin_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.fin |=> in_ready_o)
    else $error("no return to load after final result");

endmodule

[rtl/core/kmst_dp.sv]
// Datapath: edge memory, ordered scan, union-find store and result registers.
module kmst_dp
  import kmst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kmst_cmd_t                     cmd_i,
  output kmst_stat_t                    stat_o,
  input  logic                          cfg_we_i,
  input  logic [VC_W-1:0]               cfg_data_i,
  input  logic [VTX_W-1:0]              edge_src_i,
  input  logic [VTX_W-1:0]              edge_dest_i,
  input  logic signed [WEIGHT_BITS-1:0] edge_weight_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [VTX_W-1:0]              tree_src_o,
  output logic [VTX_W-1:0]              tree_dest_o,
  output logic signed [WEIGHT_BITS-1:0] tree_weight_o,
  output logic                          has_edge_o,
  output logic                          spanning_o,
  output logic                          overflow_o,
  output logic                          last_result_o
);

  localparam int unsigned AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned CW  = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW  = $clog2(MAX_VERTICES);
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EDGES);
  localparam logic [7:0]    VMAX    = 8'(MAX_VERTICES);

  // edge memory
  logic [VTX_W-1:0]              mem_src [MAX_EDGES];
  logic [VTX_W-1:0]              mem_dst [MAX_EDGES];
  logic signed [WEIGHT_BITS-1:0] mem_w   [MAX_EDGES];

  logic [VC_W-1:0] vc_raw_q;
  logic [7:0]      vc_eff;
  logic [CW-1:0]   cnt_q;
  logic            ovf_q;

  // scan
  logic [AW-1:0]                 rd_addr_q, rd_idx_q;
  logic                          rd_vld_q;
  logic [VTX_W-1:0]              rd_src_q, rd_dst_q;
  logic signed [WEIGHT_BITS-1:0] rd_w_q;
  logic                          best_vld_q, have_last_q;
  logic [AW-1:0]                 best_idx_q, last_idx_q;
  logic [VTX_W-1:0]              best_src_q, best_dst_q;
  logic signed [WEIGHT_BITS-1:0] best_w_q, last_w_q;
  logic                          after_last, take;

  // union-find
  logic [PW-1:0] par_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] pvld_q;
  logic [PW-1:0] walk_q, root_s_q, par_rd;
  logic [VCW-1:0] found_q;

  // pending chosen edge
  logic                          pend_vld_q;
  logic [VTX_W-1:0]              pend_src_q, pend_dst_q;
  logic signed [WEIGHT_BITS-1:0] pend_w_q;

  logic in_range, spanning;

  always_comb begin
    if (vc_raw_q == '0)               vc_eff = 8'd1;
    else if (8'(vc_raw_q) > VMAX)     vc_eff = VMAX;
    else                              vc_eff = 8'(vc_raw_q);
  end

  assign in_range = (8'(edge_src_i) < vc_eff) && (8'(edge_dest_i) < vc_eff);
  assign spanning = (8'(found_q) + 8'd1) == vc_eff;

  assign after_last = !have_last_q || (rd_w_q > last_w_q) ||
                      ((rd_w_q == last_w_q) && (rd_idx_q > last_idx_q));
  assign take       = after_last && (!best_vld_q || (rd_w_q < best_w_q));

  assign par_rd = pvld_q[walk_q] ? par_q[walk_q] : walk_q;

  assign stat_o.stop      = ((8'(found_q) + 8'd1) >= vc_eff) || (cnt_q == '0);
  assign stat_o.scan_last = (CW'(rd_addr_q) + CW'(1)) == cnt_q;
  assign stat_o.best_vld  = best_vld_q;
  assign stat_o.walk_hit  = (par_rd == walk_q);
  assign stat_o.roots_eq  = (walk_q == root_s_q);
  assign stat_o.pend_vld  = pend_vld_q;
  assign stat_o.out_free  = !out_valid_o || out_ready_i;

  // memory: written while loading, read during scans
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_range && (cnt_q < CNT_MAX)) begin
      mem_src[cnt_q[AW-1:0]] <= edge_src_i;
      mem_dst[cnt_q[AW-1:0]] <= edge_dest_i;
      mem_w[cnt_q[AW-1:0]]   <= edge_weight_i;
    end
    rd_src_q <= mem_src[rd_addr_q];
    rd_dst_q <= mem_dst[rd_addr_q];
    rd_w_q   <= mem_w[rd_addr_q];
  end

  // payload-only registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_read) rd_idx_q <= rd_addr_q;
    if (rd_vld_q && take) begin
      best_idx_q <= rd_idx_q;
      best_src_q <= rd_src_q;
      best_dst_q <= rd_dst_q;
      best_w_q   <= rd_w_q;
    end
    if (cmd_i.pick) begin
      last_w_q   <= best_w_q;
      last_idx_q <= best_idx_q;
      walk_q     <= PW'(best_src_q);
    end
    if (cmd_i.walk_s) begin
      if (par_rd == walk_q) begin
        root_s_q <= walk_q;
        walk_q   <= PW'(best_dst_q);
      end else begin
        walk_q <= par_rd;
      end
    end
    if (cmd_i.walk_d && (par_rd != walk_q)) walk_q <= par_rd;
    if (cmd_i.union_go) begin
      par_q[root_s_q] <= walk_q;
      pend_src_q      <= best_src_q;
      pend_dst_q      <= best_dst_q;
      pend_w_q        <= best_w_q;
    end
  end

  // control-bearing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_raw_q    <= VC_RESET;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rd_addr_q   <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      have_last_q <= 1'b0;
      pvld_q      <= '0;
      found_q     <= '0;
      pend_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) vc_raw_q <= cfg_data_i;
      if (cmd_i.load && in_range) begin
        if (cnt_q < CNT_MAX) cnt_q <= cnt_q + CW'(1);
        else                 ovf_q <= 1'b1;
      end
      rd_vld_q <= cmd_i.scan_read;
      if (cmd_i.scan_begin) begin
        rd_addr_q  <= '0;
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan_read) begin
        rd_addr_q <= rd_addr_q + AW'(1);
      end
      if (rd_vld_q && take) best_vld_q <= 1'b1;
      if (cmd_i.pick && best_vld_q) have_last_q <= 1'b1;
      if (cmd_i.union_go) begin
        pvld_q[root_s_q] <= 1'b1;
        found_q          <= found_q + VCW'(1);
        pend_vld_q       <= 1'b1;
      end
      if (cmd_i.init) begin
        pvld_q      <= '0;
        have_last_q <= 1'b0;
        found_q     <= '0;
        pend_vld_q  <= 1'b0;
      end
      if (cmd_i.fin) begin
        cnt_q      <= '0;
        ovf_q      <= 1'b0;
        pend_vld_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if ((cmd_i.union_go && pend_vld_q) || cmd_i.fin) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.union_go && pend_vld_q) begin
      tree_src_o    <= pend_src_q;
      tree_dest_o   <= pend_dst_q;
      tree_weight_o <= pend_w_q;
      has_edge_o    <= 1'b1;
      spanning_o    <= 1'b0;
      overflow_o    <= 1'b0;
      last_result_o <= 1'b0;
    end else if (cmd_i.fin) begin
      tree_src_o    <= pend_vld_q ? pend_src_q : '0;
      tree_dest_o   <= pend_vld_q ? pend_dst_q : '0;
      tree_weight_o <= pend_vld_q ? pend_w_q : '0;
      has_edge_o    <= pend_vld_q;
      spanning_o    <= spanning;
      overflow_o    <= ovf_q;
      last_result_o <= 1'b1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("edge count beyond capacity");
  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q < VCW'(MAX_VERTICES))
    else $error("more tree edges than vertices allow");
  a_rd_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_read |=> rd_vld_q)
    else $error("scan read data not marked valid");

endmodule

[rtl/core/kruskal_minimum_spanning_tree.sv]
// Top level of the Kruskal minimum spanning tree block with union-find.
//
//  channel   | dir | contents
//  s_axis    | in  | tdata: edge_src[3:0], edge_dest[7:4], edge_weight[8+:W]; tlast: last_edge
//  m_axis    | out | tdata: tree_src, tree_dest, tree_weight, spanning, overflow;
//            |     | tuser: has_edge; tlast: last_result
//  cfg       | in  | cfg_wr_en_i / cfg_wr_data_i: vertex_count
//
// Edges load one per cycle while s_axis_tready is high. After the request marked tlast,
// each edge examined, in (weight, arrival) order, passes a check, a scan of the stored
// edges, a scan end, a pick, a root walk per side and a union step when roots differ;
// this stops once V-1 tree edges are found or no edge is left. Reset clears counters,
// parent-valid bits and the state machine, not the edge memory. A stalled output holds
// the search at the next emit; a chosen edge is held back so the final flags ride on it.
module kruskal_minimum_spanning_tree
  import kmst_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned MAX_EDGES    = 64,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_wr_en_i,
  input  logic [VC_W-1:0]                      cfg_wr_data_i,   // vertex_count
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // edge_src, edge_dest, edge_weight from bit 0 up
  input  logic [((8+WEIGHT_BITS+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tree_src, tree_dest, tree_weight, spanning, overflow from bit 0 up
  output logic [((10+WEIGHT_BITS+7)/8)*8-1:0]  m_axis_tdata,
  output logic                                 m_axis_tuser,    // has_edge
  output logic                                 m_axis_tlast
);

  localparam int unsigned TDO_W = ((10 + WEIGHT_BITS + 7) / 8) * 8;

  kmst_cmd_t  cmd;
  kmst_stat_t stat;

  logic [VTX_W-1:0]              t_src, t_dst;
  logic signed [WEIGHT_BITS-1:0] t_w;
  logic                          t_span, t_ovf;

  kmst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kmst_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_wr_en_i),
    .cfg_data_i    (cfg_wr_data_i),
    .edge_src_i    (s_axis_tdata[3:0]),
    .edge_dest_i   (s_axis_tdata[7:4]),
    .edge_weight_i (s_axis_tdata[8 +: WEIGHT_BITS]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .tree_src_o    (t_src),
    .tree_dest_o   (t_dst),
    .tree_weight_o (t_w),
    .has_edge_o    (m_axis_tuser),
    .spanning_o    (t_span),
    .overflow_o    (t_ovf),
    .last_result_o (m_axis_tlast)
  );

  assign m_axis_tdata = TDO_W'({t_ovf, t_span, t_w, t_dst, t_src});

endmodule
